// File: sv/ple_pkg.sv
package ple_pkg;

    // Field widths fixed by the request and result formats.
    localparam int ActionW   = 3;
    localparam int PositionW = 6;
    localparam int ValueW    = 32;
    localparam int StatusW   = 3;

    // Widths of the command fields, sized for the largest supported list (64 entries).
    localparam int IdxW = 6;
    localparam int CntW = 7;

    // A display never produces more results than this.
    localparam int ResultLimit = 32;

    typedef enum logic [ActionW-1:0] {
        ACT_INSERT_FRONT = 3'd0,
        ACT_INSERT_AT    = 3'd1,
        ACT_INSERT_BACK  = 3'd2,
        ACT_DELETE_FRONT = 3'd3,
        ACT_DELETE_AT    = 3'd4,
        ACT_DELETE_BACK  = 3'd5,
        ACT_DISPLAY      = 3'd6,
        ACT_UNUSED       = 3'd7
    } action_t;

    typedef enum logic [StatusW-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_CLAMPED = 3'd2,
        STAT_NODEL   = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_DELETE,
        CMD_REPORT,
        CMD_DISPLAY
    } cmd_kind_t;

    // One classified request, passed from the front part to the back part.
    typedef struct packed {
        cmd_kind_t                kind;
        status_t                  status;
        logic [IdxW-1:0]          index;
        logic [CntW-1:0]          len;
        logic signed [ValueW-1:0] value;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_DISPLAY
    } back_state_t;

endpackage

// File: sv/ple_req_if.sv
interface ple_req_if;

    logic                                 valid;
    logic                                 ready;
    logic [ple_pkg::ActionW-1:0]          action;
    logic [ple_pkg::PositionW-1:0]        position;
    logic signed [ple_pkg::ValueW-1:0]    value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);

endinterface

// File: sv/ple_rsp_if.sv
interface ple_rsp_if;

    logic                                 valid;
    logic                                 ready;
    logic [ple_pkg::StatusW-1:0]          status;
    logic signed [ple_pkg::ValueW-1:0]    item_value;
    logic                                 last;

    modport source (output valid, status, item_value, last, input ready);
    modport sink   (input valid, status, item_value, last, output ready);

endinterface

// File: sv/ple_front.sv
module ple_front #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    ple_req_if.sink        req,
    output ple_pkg::cmd_t  cmd,
    output logic           cmd_valid,
    input  logic           cmd_ready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > ple_pkg::PositionW) ? CW : ple_pkg::PositionW) + 1;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] last_idx_w;
    logic          known_action;
    logic          push;

    // Position zero counts as position one; both operands are widened for comparison.
    assign pos_w      = (req.position == '0) ? WW'(1) : WW'(req.position);
    assign cnt_w      = WW'(count_reg);
    assign last_idx_w = cnt_w - WW'(1);

    assign known_action = (req.action != ple_pkg::ACT_UNUSED);
    assign req.ready    = cmd_ready;
    assign cmd_valid    = req.valid && known_action;
    assign push         = cmd_valid && cmd_ready;

    // Classify the request against the running element count.
    always_comb
    begin
        cmd.kind   = ple_pkg::CMD_REPORT;
        cmd.status = ple_pkg::STAT_OK;
        cmd.index  = '0;
        cmd.len    = ple_pkg::CntW'(count_reg);
        cmd.value  = req.value;
        unique case (req.action) inside
            ple_pkg::ACT_INSERT_FRONT, ple_pkg::ACT_INSERT_AT, ple_pkg::ACT_INSERT_BACK:
            begin
                if (cnt_w >= WW'(DEPTH))
                begin
                    cmd.status = ple_pkg::STAT_FULL;
                end
                else if (req.action == ple_pkg::ACT_INSERT_FRONT
                         || (req.action == ple_pkg::ACT_INSERT_AT && pos_w == WW'(1)))
                begin
                    cmd.kind = ple_pkg::CMD_INSERT;
                end
                else if (req.action == ple_pkg::ACT_INSERT_BACK)
                begin
                    cmd.kind  = ple_pkg::CMD_INSERT;
                    cmd.index = ple_pkg::IdxW'(cnt_w);
                end
                else if (cnt_w == '0)
                begin
                    cmd.status = ple_pkg::STAT_EMPTY;
                end
                else if (pos_w > cnt_w + WW'(1))
                begin
                    cmd.kind   = ple_pkg::CMD_INSERT;
                    cmd.status = ple_pkg::STAT_CLAMPED;
                    cmd.index  = ple_pkg::IdxW'(cnt_w);
                end
                else
                begin
                    cmd.kind  = ple_pkg::CMD_INSERT;
                    cmd.index = ple_pkg::IdxW'(pos_w - WW'(1));
                end
            end
            ple_pkg::ACT_DELETE_FRONT, ple_pkg::ACT_DELETE_AT, ple_pkg::ACT_DELETE_BACK:
            begin
                if (cnt_w == '0)
                begin
                    cmd.status = ple_pkg::STAT_EMPTY;
                end
                else if (req.action == ple_pkg::ACT_DELETE_FRONT
                         || (req.action == ple_pkg::ACT_DELETE_AT && pos_w == WW'(1)))
                begin
                    cmd.kind = ple_pkg::CMD_DELETE;
                end
                else if (req.action == ple_pkg::ACT_DELETE_BACK)
                begin
                    cmd.kind  = ple_pkg::CMD_DELETE;
                    cmd.index = ple_pkg::IdxW'(last_idx_w);
                end
                else if (cnt_w == WW'(1))
                begin
                    cmd.status = ple_pkg::STAT_NODEL;
                end
                else if (pos_w > cnt_w)
                begin
                    cmd.kind   = ple_pkg::CMD_DELETE;
                    cmd.status = ple_pkg::STAT_CLAMPED;
                    cmd.index  = ple_pkg::IdxW'(last_idx_w);
                end
                else
                begin
                    cmd.kind  = ple_pkg::CMD_DELETE;
                    cmd.index = ple_pkg::IdxW'(pos_w - WW'(1));
                end
            end
            ple_pkg::ACT_DISPLAY:
            begin
                if (cnt_w == '0)
                begin
                    cmd.status = ple_pkg::STAT_EMPTY;
                end
                else
                begin
                    cmd.kind = ple_pkg::CMD_DISPLAY;
                end
            end
            default:
            begin
                cmd.kind = ple_pkg::CMD_REPORT;
            end
        endcase
    end

    // The count is tracked here so that later requests are classified without waiting.
    always_comb
    begin
        count_next = count_reg;
        if (push && cmd.kind == ple_pkg::CMD_INSERT)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (push && cmd.kind == ple_pkg::CMD_DELETE)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds list depth");

    a_no_delete_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.kind == ple_pkg::CMD_DELETE) |-> (count_reg != '0))
        else $error("delete issued on an empty list");

endmodule

// File: sv/ple_cmd_queue.sv
module ple_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  ple_pkg::cmd_t  in_cmd,
    input  logic           in_valid,
    output logic           in_ready,
    output ple_pkg::cmd_t  out_cmd,
    output logic           out_valid,
    input  logic           out_ready
);

    ple_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    logic          pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Storage for the two entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ((fill_reg == 2'd0) || (fill_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

endmodule

// File: sv/ple_back.sv
module ple_back #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ple_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    ple_rsp_if.source      rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [ple_pkg::ValueW-1:0] cell_reg [DEPTH];

    ple_pkg::back_state_t              state_reg;
    ple_pkg::back_state_t              state_next;
    logic [CW-1:0]                     step_reg;
    logic [CW-1:0]                     step_next;
    logic [CW-1:0]                     len_reg;
    logic [CW-1:0]                     len_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    ple_pkg::status_t                  status_reg;
    ple_pkg::status_t                  status_next;
    logic signed [ple_pkg::ValueW-1:0] value_reg;
    logic signed [ple_pkg::ValueW-1:0] value_next;
    logic                              last_reg;
    logic                              last_next;

    logic          slot_free;
    logic          do_insert;
    logic          do_delete;
    logic          do_rotate;
    logic [IW-1:0] idx;
    logic [CW-1:0] rot_top;
    logic          disp_emit;
    logic          disp_last;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign idx       = cmd.index[IW-1:0];
    assign rot_top   = len_reg - CW'(1);
    assign disp_emit = (int'(step_reg) < ple_pkg::ResultLimit);
    assign disp_last = (step_reg + CW'(1) == len_reg)
                    || (int'(step_reg) + 1 == ple_pkg::ResultLimit);

    // Sequencer: one command, or one display element, per cycle when slot_free.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        cmd_ready      = 1'b0;
        do_insert      = 1'b0;
        do_delete      = 1'b0;
        do_rotate      = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ple_pkg::BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        ple_pkg::CMD_INSERT, ple_pkg::CMD_REPORT:
                        begin
                            do_insert      = (cmd.kind == ple_pkg::CMD_INSERT);
                            out_valid_next = 1'b1;
                            status_next    = cmd.status;
                            value_next     = '0;
                            last_next      = 1'b1;
                        end
                        ple_pkg::CMD_DELETE:
                        begin
                            do_delete      = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = cmd.status;
                            value_next     = cell_reg[idx];
                            last_next      = 1'b1;
                        end
                        ple_pkg::CMD_DISPLAY:
                        begin
                            state_next = ple_pkg::BK_DISPLAY;
                            step_next  = '0;
                            len_next   = cmd.len[CW-1:0];
                        end
                        default:
                        begin
                            state_next = ple_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            ple_pkg::BK_DISPLAY:
            begin
                if (slot_free)
                begin
                    do_rotate = 1'b1;
                    if (disp_emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ple_pkg::STAT_OK;
                        value_next     = cell_reg[0];
                        last_next      = disp_last;
                    end
                    step_next = step_reg + CW'(1);
                    if (step_reg == rot_top)
                    begin
                        state_next = ple_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ple_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::BK_IDLE;
            step_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register contents.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    // Cells shift in parallel: open a gap, close a gap, or rotate the stored part by one.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_insert)
            begin
                if (IW'(i) == idx)
                begin
                    cell_reg[i] <= cmd.value;
                end
                else if (i > 0 && IW'(i) > idx)
                begin
                    cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_delete)
            begin
                if (i < DEPTH - 1 && IW'(i) >= idx)
                begin
                    cell_reg[i] <= cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
            else if (do_rotate)
            begin
                if (CW'(i) == rot_top)
                begin
                    cell_reg[i] <= cell_reg[0];
                end
                else if (i < DEPTH - 1)
                begin
                    cell_reg[i] <= cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.item_value = value_reg;
    assign rsp.last       = last_reg;

    a_disp_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::BK_DISPLAY) |-> (len_reg != '0 && step_reg < len_reg))
        else $error("display walk outside the stored elements");

    a_no_pop_in_display: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::BK_DISPLAY) |-> !cmd_ready)
        else $error("command taken while a display is in progress");

endmodule

// File: sv/positional_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit words held in a row of cells that shift in
// parallel. A front part classifies each request against its own running element count and
// places it in a two-entry command queue; a back part edits the cells and drives a registered
// result. Inserts, deletes and rejected requests give one result transfer each. A display
// takes the command and then walks the stored elements, rotating the stored part of the
// list by one cell per cycle while the result register is free and emitting a result for
// each of the first 32 (the final one marked last). Action code 7 is accepted and dropped.
// Every back-part step waits for the result register to be free, so a stalled result stops
// it, while the front part keeps accepting until the queue is full.
module positional_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    ple_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          front_ready;
    ple_pkg::cmd_t back_cmd;
    logic          back_valid;
    logic          back_ready;

    ple_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    ple_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (back_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    ple_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );

endmodule

// File: tb/ple_list_check_pkg.sv
package ple_list_check_pkg;

    // One result transfer as the list engine should produce it.
    typedef struct {
        ple_pkg::status_t                  status;
        logic signed [ple_pkg::ValueW-1:0] item_value;
        logic                              last;
    } list_result_t;

    class list_scoreboard;

        int unsigned                       capacity;
        logic signed [ple_pkg::ValueW-1:0] cells[$];
        list_result_t                      expected_results[$];
        int unsigned                       errors;

        function new(int unsigned max_entries);
            capacity = max_entries;
            errors   = 0;
        endfunction

        function int unsigned element_count();
            return cells.size();
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction

        function void push_result(ple_pkg::status_t st, logic signed [ple_pkg::ValueW-1:0] v,
                                  logic lst);
            list_result_t r;
            r.status     = st;
            r.item_value = v;
            r.last       = lst;
            expected_results.push_back(r);
        endfunction

        // Applies one accepted request to the list copy and queues its results.
        function void note_request(logic [ple_pkg::ActionW-1:0] action,
                                   logic [ple_pkg::PositionW-1:0] position,
                                   logic signed [ple_pkg::ValueW-1:0] value);
            int unsigned                       pos;
            int unsigned                       cnt;
            int unsigned                       n;
            logic signed [ple_pkg::ValueW-1:0] taken;
            pos = (position == 0) ? 1 : position;
            cnt = cells.size();
            case (action) inside
                ple_pkg::ACT_INSERT_FRONT, ple_pkg::ACT_INSERT_AT, ple_pkg::ACT_INSERT_BACK:
                begin
                    // A full list rejects every insert before anything else is looked at.
                    if (cnt >= capacity)
                        push_result(ple_pkg::STAT_FULL, '0, 1'b1);
                    else if (action == ple_pkg::ACT_INSERT_FRONT
                             || (action == ple_pkg::ACT_INSERT_AT && pos == 1))
                    begin
                        cells.push_front(value);
                        push_result(ple_pkg::STAT_OK, '0, 1'b1);
                    end
                    else if (action == ple_pkg::ACT_INSERT_BACK)
                    begin
                        cells.push_back(value);
                        push_result(ple_pkg::STAT_OK, '0, 1'b1);
                    end
                    else if (cnt == 0)
                        push_result(ple_pkg::STAT_EMPTY, '0, 1'b1);
                    else if (pos > cnt + 1)
                    begin
                        cells.push_back(value);
                        push_result(ple_pkg::STAT_CLAMPED, '0, 1'b1);
                    end
                    else
                    begin
                        cells.insert(pos - 1, value);
                        push_result(ple_pkg::STAT_OK, '0, 1'b1);
                    end
                end
                ple_pkg::ACT_DELETE_FRONT, ple_pkg::ACT_DELETE_AT, ple_pkg::ACT_DELETE_BACK:
                begin
                    if (cnt == 0)
                        push_result(ple_pkg::STAT_EMPTY, '0, 1'b1);
                    else if (action == ple_pkg::ACT_DELETE_FRONT
                             || (action == ple_pkg::ACT_DELETE_AT && pos == 1))
                    begin
                        taken = cells.pop_front();
                        push_result(ple_pkg::STAT_OK, taken, 1'b1);
                    end
                    else if (action == ple_pkg::ACT_DELETE_BACK)
                    begin
                        taken = cells.pop_back();
                        push_result(ple_pkg::STAT_OK, taken, 1'b1);
                    end
                    else if (cnt == 1)
                        push_result(ple_pkg::STAT_NODEL, '0, 1'b1);
                    else if (pos > cnt)
                    begin
                        taken = cells.pop_back();
                        push_result(ple_pkg::STAT_CLAMPED, taken, 1'b1);
                    end
                    else
                    begin
                        taken = cells[pos - 1];
                        cells.delete(pos - 1);
                        push_result(ple_pkg::STAT_OK, taken, 1'b1);
                    end
                end
                ple_pkg::ACT_DISPLAY:
                begin
                    if (cnt == 0)
                        push_result(ple_pkg::STAT_EMPTY, '0, 1'b1);
                    else
                    begin
                        n = (cnt < ple_pkg::ResultLimit) ? cnt : ple_pkg::ResultLimit;
                        for (int i = 0; i < n; i++)
                            push_result(ple_pkg::STAT_OK, cells[i], (i == n - 1));
                    end
                end
                default:
                begin
                    // The unused action code leaves the list alone and gives no result.
                end
            endcase
        endfunction

        // Compares one result transfer with the oldest expected result.
        function void check_result(logic [ple_pkg::StatusW-1:0] status,
                                   logic signed [ple_pkg::ValueW-1:0] item_value,
                                   logic last);
            list_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $display(
                    "%0t: unexpected result: expected none, got status %0d value %0d last %0d",
                    $time, status, item_value, last);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (status !== exp_r.status)
            begin
                $display("%0t: status mismatch: expected %0d, got %0d", $time, exp_r.status, status);
                errors++;
            end
            if (item_value !== exp_r.item_value)
            begin
                $display("%0t: item_value mismatch: expected %0d, got %0d",
                         $time, exp_r.item_value, item_value);
                errors++;
            end
            if (last !== exp_r.last)
            begin
                $display("%0t: last mismatch: expected %0d, got %0d", $time, exp_r.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

// File: tb/tb_positional_list_engine.sv
module tb_positional_list_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                                DEPTH         = 32;
    localparam int                                RandomItems   = 330;
    localparam int                                WatchdogLimit = 2000;
    localparam int                                DrainCycles   = 40;
    localparam logic [ple_pkg::ActionW-1:0]       ActUnused     = 3'd7;
    localparam logic signed [ple_pkg::ValueW-1:0] ValMax        = 32'sh7FFF_FFFF;
    localparam logic signed [ple_pkg::ValueW-1:0] ValMin        = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    ple_list_check_pkg::list_scoreboard sb;

    int unsigned src_idle_pct = 31;
    int unsigned rcv_idle_pct = 57;
    int unsigned stall_cycles = 0;
    bit          growing      = 1'b1;

    positional_list_engine #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Every result transfer is checked at the clock edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.item_value, rsp_ch.last);
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long.
    initial
    begin
        while (stall_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("** positional_list_engine: FAILED **");
        $finish;
    end

    // Offers one request, holding it until the engine takes it, and records it on transfer.
    task automatic send_request(input logic [ple_pkg::ActionW-1:0] act,
                                input logic [ple_pkg::PositionW-1:0] pos,
                                input logic signed [ple_pkg::ValueW-1:0] val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(act, pos, val);
        @(negedge clk);
    endtask

    // Chooses a request that leans towards filling or draining the list.
    task automatic pick_request(output logic [ple_pkg::ActionW-1:0] act,
                                output logic [ple_pkg::PositionW-1:0] pos,
                                output logic signed [ple_pkg::ValueW-1:0] val);
        int unsigned cnt;
        int unsigned r;
        cnt = sb.element_count();
        r   = $urandom_range(99);
        if (r >= 97)
            act = ActUnused;
        else if (r >= 88)
            act = ple_pkg::ACT_DISPLAY;
        else if ((growing && r < 75) || (!growing && r < 12))
            act = ple_pkg::ActionW'(ple_pkg::ACT_INSERT_FRONT + $urandom_range(2));
        else
            act = ple_pkg::ActionW'(ple_pkg::ACT_DELETE_FRONT + $urandom_range(2));

        // Positions mostly fall inside the list, sometimes zero, just past it or anywhere.
        r = $urandom_range(9);
        if (r <= 6)
            pos = ple_pkg::PositionW'($urandom_range(cnt + 1, 1));
        else if (r == 7)
            pos = '0;
        else if (r == 8)
            pos = ple_pkg::PositionW'($urandom_range(63));
        else
            pos = ple_pkg::PositionW'(cnt + 1 + $urandom_range(1));

        r = $urandom_range(7);
        if (r == 0)
            val = ValMax;
        else if (r == 1)
            val = ValMin;
        else
            val = $urandom;
    endtask

    initial
    begin
        logic [ple_pkg::ActionW-1:0]       act;
        logic [ple_pkg::PositionW-1:0]     pos;
        logic signed [ple_pkg::ValueW-1:0] val;
        int                                done_items;

        sb              = new(DEPTH);
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty-list cases, position zero, single element, clamping.
        send_request(ple_pkg::ACT_DELETE_FRONT, 6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_BACK,  6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DISPLAY,      6'd1, 32'sd0);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd2, 32'sd5);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd0, ValMax);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd2, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd0, 32'sd0);
        send_request(ple_pkg::ACT_INSERT_FRONT, 6'd1, ValMax);
        send_request(ple_pkg::ACT_INSERT_BACK,  6'd1, ValMin);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd63, -32'sd1);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd2, 32'sd0);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd5, 32'sh5555_5555);
        send_request(ple_pkg::ACT_INSERT_AT,    6'd33, 32'shAAAA_AAAA);
        send_request(ple_pkg::ACT_DISPLAY,      6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd2, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd63, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_AT,    6'd4, 32'sd0);
        send_request(ActUnused,                 6'd1, 32'sd1);
        send_request(ple_pkg::ACT_DELETE_BACK,  6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DISPLAY,      6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_FRONT, 6'd1, 32'sd0);
        send_request(ple_pkg::ACT_DELETE_FRONT, 6'd1, 32'sd0);

        // Random part, in three idling phases; the unused action does not count.
        done_items = 0;
        while (done_items < RandomItems)
        begin
            if (done_items >= 2 * RandomItems / 3)
            begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            else if (done_items >= RandomItems / 3)
            begin
                src_idle_pct = 57;
                rcv_idle_pct = 31;
            end
            pick_request(act, pos, val);
            send_request(act, pos, val);
            if (act != ActUnused)
                done_items++;

            // Swing between filling to capacity and draining to empty.
            if (sb.element_count() == DEPTH && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (sb.element_count() == 0 && $urandom_range(2) == 0)
                growing = 1'b1;
        end
        req_ch.valid <= 1'b0;

        // Let every outstanding result arrive, then watch for strays.
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (sb.errors == 0)
            $display("** positional_list_engine: PASSED **");
        else
            $display("** positional_list_engine: FAILED **");
        $finish;
    end

endmodule
